// File: rtl/core/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg: shared definitions for the motor feedback decoder
// Field widths, angle scaling constants and configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package mfd_pkg;

    // Input field widths
    localparam int COUNT_W = 13;
    localparam int RPM_W   = 16;
    localparam int CUR_W   = 16;
    localparam int TEMP_W  = 8;

    // Output field widths
    localparam int SINGLE_W   = 25;
    localparam int TOTAL_W    = 57;
    localparam int TURN_OUT_W = 32;
    localparam int SPEED_W    = 27;
    localparam int CURRENT_W  = 24;

    // Encoder geometry
    localparam int COUNTS_PER_TURN = 1 << COUNT_W;
    localparam int HALF_TURN       = COUNTS_PER_TURN / 2;
    localparam int DEG_PER_TURN    = 360;
    localparam int FULL_TURN_ANGLE = DEG_PER_TURN * 65536;
    localparam int COUNT_ANGLE     = FULL_TURN_ANGLE / COUNTS_PER_TURN;

    // Turn counter default width
    localparam int TURN_BITS_DEF = 32;

    // Filter weights, Q1.16
    localparam int ALPHA_W    = 17;
    localparam int ALPHA_FRAC = 16;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(65536);

    // Scale factors of the filter targets
    localparam int RPM_TO_SPEED = 1536;
    localparam int CUR_TO_AVG   = 256;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_ALPHA   = 1'b0,
        CFG_CURRENT_ALPHA = 1'b1
    } cfg_index_t;

endpackage

`default_nettype wire

// File: rtl/core/motor_feedback_decoder.sv
// ----------------------------------------------------------------------------
// motor_feedback_decoder: encoder unwrap, angle scaling and EMA filters
// Turns one feedback frame into single-turn and multi-turn angles, a turn
// count, smoothed speed and current, and the temperature byte.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------
//  in      | in_valid / in_stall     | encoder_count speed_rpm current_raw
//          |                         | temperature
//  out     | out_valid / out_stall   | single_angle multi_angle turn_count
//          |                         | speed_filtered current_filtered
//          |                         | temperature_out
//  cfg     | cfg_wr_en               | cfg_index cfg_data
//
//  One frame per cycle sustained while out_stall is low; a frame passes through
//  the input register, then the result register. The turn counter and both filter
//  averages update in the same cycle a frame moves to the result register; that
//  feedback loop through the filter multiplier sets the clock limit.
//  Reset clears the valid flags, turn state and filter averages, not the payload;
//  filter weights reset to 65536 (no smoothing). A stalled result holds the
//  frame in the input register; in_stall rises only when both registers are full.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_feedback_decoder #(
    parameter int TURN_BITS = mfd_pkg::TURN_BITS_DEF
) (
    input  wire  logic                                   clk,
    input  wire  logic                                   rst_n,

    // Configuration write port
    input  wire  logic                                   cfg_wr_en,
    input  wire  logic        [mfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  logic        [mfd_pkg::ALPHA_W-1:0]     cfg_data,

    // Input frame
    input  wire  logic                                   in_valid,
    output logic                                         in_stall,
    input  wire  logic        [mfd_pkg::COUNT_W-1:0]     encoder_count,
    input  wire  logic signed [mfd_pkg::RPM_W-1:0]       speed_rpm,
    input  wire  logic signed [mfd_pkg::CUR_W-1:0]       current_raw,
    input  wire  logic        [mfd_pkg::TEMP_W-1:0]      temperature,

    // Result
    output logic                                         out_valid,
    input  wire  logic                                   out_stall,
    output logic              [mfd_pkg::SINGLE_W-1:0]    single_angle,
    output logic signed       [mfd_pkg::TOTAL_W-1:0]     multi_angle,
    output logic signed       [mfd_pkg::TURN_OUT_W-1:0]  turn_count,
    output logic signed       [mfd_pkg::SPEED_W-1:0]     speed_filtered,
    output logic signed       [mfd_pkg::CURRENT_W-1:0]   current_filtered,
    output logic              [mfd_pkg::TEMP_W-1:0]      temperature_out
);

    localparam int CW = mfd_pkg::COUNT_W;
    localparam int PW = TURN_BITS + CW;     // {turns, count} position width

    localparam logic signed [CW:0] HALF_POS = (CW + 1)'(mfd_pkg::HALF_TURN);
    localparam logic signed [CW:0] HALF_NEG = -HALF_POS;
    localparam logic signed [mfd_pkg::TOTAL_W-1:0] ANGLE_STEP =
        mfd_pkg::TOTAL_W'(mfd_pkg::COUNT_ANGLE);
    localparam logic [mfd_pkg::SINGLE_W-1:0] SINGLE_STEP =
        mfd_pkg::SINGLE_W'(mfd_pkg::COUNT_ANGLE);

    // Configuration registers
    logic [mfd_pkg::ALPHA_W-1:0] speed_alpha_reg;
    logic [mfd_pkg::ALPHA_W-1:0] current_alpha_reg;

    // Input register
    logic                               s0_valid_reg;
    logic                               s0_valid_next;
    logic        [CW-1:0]               s0_count_reg;
    logic signed [mfd_pkg::RPM_W-1:0]   s0_rpm_reg;
    logic signed [mfd_pkg::CUR_W-1:0]   s0_cur_reg;
    logic        [mfd_pkg::TEMP_W-1:0]  s0_temp_reg;

    // Result register and state
    logic                                   out_valid_reg;
    logic                                   out_valid_next;
    logic        [mfd_pkg::SINGLE_W-1:0]    single_reg;
    logic        [mfd_pkg::SINGLE_W-1:0]    single_next;
    logic signed [mfd_pkg::TOTAL_W-1:0]     total_reg;
    logic signed [mfd_pkg::TOTAL_W-1:0]     total_next;
    logic        [mfd_pkg::TEMP_W-1:0]      temp_reg;
    logic        [CW-1:0]                   last_count_reg;
    logic signed [TURN_BITS-1:0]            turns_reg;
    logic signed [TURN_BITS-1:0]            turns_next;

    // Datapath
    logic                                   advance;
    logic                                   in_take;
    logic signed [CW:0]                     delta;
    logic signed [PW-1:0]                   position;
    logic signed [mfd_pkg::SPEED_W-1:0]     speed_target;
    logic signed [mfd_pkg::CURRENT_W-1:0]   current_target;

    // Pipeline control
    assign advance        = s0_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = s0_valid_reg && !advance;
    assign in_take        = in_valid && !in_stall;
    assign s0_valid_next  = in_take || (s0_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    // Configuration decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_alpha_reg   <= mfd_pkg::ALPHA_RESET;
            current_alpha_reg <= mfd_pkg::ALPHA_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (mfd_pkg::cfg_index_t'(cfg_index))
                mfd_pkg::CFG_SPEED_ALPHA:   speed_alpha_reg   <= cfg_data;
                mfd_pkg::CFG_CURRENT_ALPHA: current_alpha_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s0_count_reg <= encoder_count;
            s0_rpm_reg   <= speed_rpm;
            s0_cur_reg   <= current_raw;
            s0_temp_reg  <= temperature;
        end
    end

    // Turn unwrap: a jump of more than half a turn crosses the index
    assign delta = signed'({1'b0, s0_count_reg}) - signed'({1'b0, last_count_reg});

    always_comb
    begin
        if (delta > HALF_POS)
        begin
            turns_next = turns_reg - TURN_BITS'(1);
        end
        else if (delta < HALF_NEG)
        begin
            turns_next = turns_reg + TURN_BITS'(1);
        end
        else
        begin
            turns_next = turns_reg;
        end
    end

    // Angles: total = (turns * counts_per_turn + count) * count_angle;
    // the constant multiply reduces to a few shifted adds
    assign position    = signed'({turns_next, s0_count_reg});
    assign total_next  = mfd_pkg::TOTAL_W'(mfd_pkg::TOTAL_W'(position) * ANGLE_STEP);
    assign single_next = mfd_pkg::SINGLE_W'(s0_count_reg) * SINGLE_STEP;

    // Turn state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg <= '0;
            turns_reg      <= '0;
        end
        else if (advance)
        begin
            last_count_reg <= s0_count_reg;
            turns_reg      <= turns_next;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            single_reg <= single_next;
            total_reg  <= total_next;
            temp_reg   <= s0_temp_reg;
        end
    end

    // Filter targets: speed in 1/256 deg/s, current in 1/256 units
    assign speed_target   = mfd_pkg::SPEED_W'(s0_rpm_reg) *
                            mfd_pkg::SPEED_W'(mfd_pkg::RPM_TO_SPEED);
    assign current_target = mfd_pkg::CURRENT_W'(s0_cur_reg) *
                            mfd_pkg::CURRENT_W'(mfd_pkg::CUR_TO_AVG);

    mfd_ema #(
        .W (mfd_pkg::SPEED_W)
    ) u_speed_ema (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .alpha  (speed_alpha_reg),
        .target (speed_target),
        .avg    (speed_filtered)
    );

    mfd_ema #(
        .W (mfd_pkg::CURRENT_W)
    ) u_current_ema (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (advance),
        .alpha  (current_alpha_reg),
        .target (current_target),
        .avg    (current_filtered)
    );

    // Outputs
    assign out_valid       = out_valid_reg;
    assign single_angle    = single_reg;
    assign multi_angle     = total_reg;
    assign turn_count      = mfd_pkg::TURN_OUT_W'(turns_reg);
    assign temperature_out = temp_reg;

`ifndef NO_ASSERTIONS
    // Turn counter moves by at most one per frame
    a_turn_step: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (turns_reg == $past(turns_reg)) ||
                    (turns_reg == $past(turns_reg) + TURN_BITS'(1)) ||
                    (turns_reg == $past(turns_reg) - TURN_BITS'(1)))
        else $error("turn counter jumped by more than one");

    // State changes only when a frame moves to the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(turns_reg) && $stable(last_count_reg) &&
                     $stable(speed_filtered) && $stable(current_filtered))
        else $error("state changed without a frame transfer");

    // Input side stalls only with a frame held in the input register
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s0_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled with room in the pipeline");

    // A frame moved forward is presented on the output next cycle
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("frame lost between input and result register");
`endif

endmodule

`default_nettype wire

// File: rtl/core/mfd_ema.sv
// ----------------------------------------------------------------------------
// mfd_ema: exponential moving average with saturation
// Holds one average; on update takes avg + floor(alpha * (target - avg) / 2^16)
// clamped to the signed range of W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_ema #(
    parameter int W = mfd_pkg::SPEED_W
) (
    input  wire  logic                              clk,
    input  wire  logic                              rst_n,
    input  wire  logic                              update,
    input  wire  logic        [mfd_pkg::ALPHA_W-1:0] alpha,
    input  wire  logic signed [W-1:0]               target,
    output logic signed       [W-1:0]               avg
);

    localparam int DW = W + 1;                      // difference width
    localparam int AW = mfd_pkg::ALPHA_W + 1;       // signed weight width
    localparam int PW = DW + AW;                    // product width
    localparam int QW = PW - mfd_pkg::ALPHA_FRAC;   // shifted product width
    localparam int SW = QW + 1;                     // sum width

    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic signed [W-1:0]  avg_reg;
    logic signed [W-1:0]  avg_next;
    logic signed [DW-1:0] diff;
    logic signed [AW-1:0] alpha_s;
    logic signed [PW-1:0] prod;
    logic signed [QW-1:0] step;
    logic signed [SW-1:0] sum;

    // Error term and weighted step; the arithmetic shift floors toward -inf
    assign diff    = DW'(target) - DW'(avg_reg);
    assign alpha_s = signed'({1'b0, alpha});
    assign prod    = PW'(diff) * PW'(alpha_s);
    assign step    = prod[PW-1:mfd_pkg::ALPHA_FRAC];
    assign sum     = SW'(avg_reg) + SW'(step);

    // Clamp to the state range
    always_comb
    begin
        if (sum > SAT_HI)
        begin
            avg_next = SAT_HI[W-1:0];
        end
        else if (sum < SAT_LO)
        begin
            avg_next = SAT_LO[W-1:0];
        end
        else
        begin
            avg_next = sum[W-1:0];
        end
    end

    // Average register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg <= '0;
        end
        else if (update)
        begin
            avg_reg <= avg_next;
        end
    end

    assign avg = avg_reg;

endmodule

`default_nettype wire

// File: tb/sv/motor_feedback_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_feedback_decoder_tb: self-checking regression for the feedback decoder
// Feeds encoder/speed/current/temperature frames through valid/stall, predicts
// angles, turn count and filtered values in a local model of the datapath, and
// compares every result transfer field by field. Filter weights change between
// phases, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------

module motor_feedback_decoder_tb;

    import mfd_pkg::*;

    typedef struct {
        logic        [COUNT_W-1:0] count;
        logic signed [RPM_W-1:0]   rpm;
        logic signed [CUR_W-1:0]   cur;
        logic        [TEMP_W-1:0]  temp;
    } feedback_frame_t;

    typedef struct {
        logic        [SINGLE_W-1:0]   single;
        logic signed [TOTAL_W-1:0]    total;
        logic signed [TURN_OUT_W-1:0] turns;
        logic signed [SPEED_W-1:0]    speed;
        logic signed [CURRENT_W-1:0]  current;
        logic        [TEMP_W-1:0]     temp;
    } feedback_result_t;

    // DUT connections
    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    cfg_index_t                    cfg_index = CFG_SPEED_ALPHA;
    logic        [ALPHA_W-1:0]     cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic        [COUNT_W-1:0]     encoder_count = '0;
    logic signed [RPM_W-1:0]       speed_rpm = '0;
    logic signed [CUR_W-1:0]       current_raw = '0;
    logic        [TEMP_W-1:0]      temperature = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic        [SINGLE_W-1:0]    single_angle;
    logic signed [TOTAL_W-1:0]     multi_angle;
    logic signed [TURN_OUT_W-1:0]  turn_count;
    logic signed [SPEED_W-1:0]     speed_filtered;
    logic signed [CURRENT_W-1:0]   current_filtered;
    logic        [TEMP_W-1:0]      temperature_out;

    // Local copy of the decoder state and weights
    logic        [COUNT_W-1:0]     pos_last = '0;
    logic signed [TURN_OUT_W-1:0]  pos_turns = '0;
    longint                        speed_avg = 0;
    longint                        current_avg = 0;
    logic        [ALPHA_W-1:0]     speed_weight = ALPHA_RESET;
    logic        [ALPHA_W-1:0]     current_weight = ALPHA_RESET;

    feedback_frame_t               frame_q[$];
    feedback_result_t              decoded_q[$];
    feedback_frame_t               drv_frame;
    feedback_result_t              want;
    int                            gap_left = 0;
    int                            stall_left = 0;
    bit                            in_gaps_on = 1'b1;
    bit                            out_stalls_on = 1'b1;
    int                            mismatch_count = 0;

    // Stimulus generator state: last queued count and rotation profile
    logic        [COUNT_W-1:0]     walk_count = '0;
    int                            spin_rate = 0;
    int                            spin_jitter = 200;

    motor_feedback_decoder dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .encoder_count    (encoder_count),
        .speed_rpm        (speed_rpm),
        .current_raw      (current_raw),
        .temperature      (temperature),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .single_angle     (single_angle),
        .multi_angle      (multi_angle),
        .turn_count       (turn_count),
        .speed_filtered   (speed_filtered),
        .current_filtered (current_filtered),
        .temperature_out  (temperature_out)
    );

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Idle length: mostly short, now and then long
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // EMA step: avg + floor(alpha * (target - avg) / 2^16), saturated to w bits
    function automatic longint smooth(longint avg, longint target,
                                      logic [ALPHA_W-1:0] alpha, int w);
        longint hi;
        longint lo;
        longint prod;
        longint r;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        prod = longint'(alpha) * (target - avg);
        r = avg + (prod >>> ALPHA_FRAC);
        if (r > hi)
            r = hi;
        if (r < lo)
            r = lo;
        return r;
    endfunction

    // Advance the local state by one frame and build the expected result
    function automatic feedback_result_t decode_frame(feedback_frame_t f);
        feedback_result_t r;
        int jump;
        longint single;
        jump = int'(f.count) - int'(pos_last);
        if (jump > HALF_TURN)
            pos_turns = pos_turns - 1;
        else if (jump < -HALF_TURN)
            pos_turns = pos_turns + 1;
        pos_last = f.count;
        speed_avg = smooth(speed_avg, longint'(f.rpm) * RPM_TO_SPEED,
                           speed_weight, SPEED_W);
        current_avg = smooth(current_avg, longint'(f.cur) * CUR_TO_AVG,
                             current_weight, CURRENT_W);
        single = longint'(f.count) * COUNT_ANGLE;
        r.single = SINGLE_W'(single);
        r.total = TOTAL_W'(longint'(pos_turns) * FULL_TURN_ANGLE + single);
        r.turns = pos_turns;
        r.speed = SPEED_W'(speed_avg);
        r.current = CURRENT_W'(current_avg);
        r.temp = f.temp;
        return r;
    endfunction

    task automatic check_field(string name, logic signed [63:0] exp_v,
                               logic signed [63:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d",
                     $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    // Input driver: presents queued frames, predicts on each transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                decoded_q.push_back(decode_frame(drv_frame));
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (frame_q.size() != 0)
                begin
                    drv_frame = frame_q.pop_front();
                    encoder_count <= drv_frame.count;
                    speed_rpm <= drv_frame.rpm;
                    current_raw <= drv_frame.cur;
                    temperature <= drv_frame.temp;
                    in_valid <= 1'b1;
                    gap_left = in_gaps_on ? pick_idle_len() : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each result transfer, drives random stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected", $time);
                    mismatch_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("single_angle", want.single, single_angle);
                    check_field("multi_angle", want.total, multi_angle);
                    check_field("turn_count", want.turns, turn_count);
                    check_field("speed_filtered", want.speed, speed_filtered);
                    check_field("current_filtered", want.current, current_filtered);
                    check_field("temperature_out", want.temp, temperature_out);
                end
            end
            if (!out_stalls_on)
                out_stall <= 1'b0;
            else if (stall_left > 0)
                stall_left--;
            else
            begin
                out_stall <= ($urandom_range(0, 99) < 35);
                stall_left = pick_idle_len();
            end
        end
    end

    task automatic push_frame(int count, int rpm, int cur, int temp);
        feedback_frame_t f;
        f.count = COUNT_W'(count);
        f.rpm = RPM_W'(rpm);
        f.cur = CUR_W'(cur);
        f.temp = TEMP_W'(temp);
        walk_count = f.count;
        frame_q.push_back(f);
    endtask

    function automatic int pick_sample();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(0, 200) - 100;
            default: return $urandom_range(0, 65535) - 32768;
        endcase
    endfunction

    // Mostly steady rotation with jitter; some half-turn edge jumps and noise
    task automatic queue_random_frames(int n);
        int pick;
        int next;
        int edges[4];
        edges = '{HALF_TURN, -HALF_TURN, HALF_TURN + 1, -HALF_TURN - 1};
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                next = int'(walk_count) + spin_rate
                       + $urandom_range(0, 2 * spin_jitter) - spin_jitter;
            else if (pick < 88)
                next = int'(walk_count) + edges[$urandom_range(0, 3)];
            else
                next = $urandom_range(0, COUNTS_PER_TURN - 1);
            push_frame(next & (COUNTS_PER_TURN - 1), pick_sample(), pick_sample(),
                       $urandom_range(0, 255));
        end
    endtask

    // Wait until every queued frame is through and the pipeline is empty
    task automatic drain();
        while (frame_q.size() != 0 || in_valid || decoded_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(cfg_index_t idx, logic [ALPHA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_SPEED_ALPHA:   speed_weight = value;
            CFG_CURRENT_ALPHA: current_weight = value;
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Stimulus sequence
    initial
    begin
        int sp_tab[5];
        int cu_tab[5];
        int sp_w;
        int cu_w;
        sp_tab = '{131071, 0, 65536, 1, 65535};
        cu_tab = '{131071, 0, 1, 65535, 131071};

        repeat (9) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Reset weights; first frame above half a turn, then half-turn edges
        push_frame(8191, 32767, -32768, 255);
        push_frame(0, -32768, 32767, 0);
        push_frame(HALF_TURN, 0, 0, 1);
        push_frame(0, 1, -1, 128);
        push_frame(HALF_TURN + 1, -1, 1, 127);
        push_frame(0, 32767, 32767, 255);
        push_frame(1, -32768, -32768, 0);
        push_frame(8191, 100, -100, 85);
        push_frame(8191, -100, 100, 170);
        push_frame(HALF_TURN - 1, 0, 0, 0);
        spin_rate = 2500;
        queue_random_frames(60);
        drain();

        for (int p = 1; p < 10; p++)
        begin
            if (p <= 5)
            begin
                sp_w = sp_tab[p - 1];
                cu_w = cu_tab[p - 1];
            end
            else
            begin
                sp_w = $urandom_range(0, 1) ? $urandom_range(0, 65536)
                                            : $urandom_range(0, 131071);
                cu_w = $urandom_range(0, 1) ? $urandom_range(0, 65536)
                                            : $urandom_range(0, 131071);
            end
            write_cfg(CFG_SPEED_ALPHA, ALPHA_W'(sp_w));
            write_cfg(CFG_CURRENT_ALPHA, ALPHA_W'(cu_w));
            @(posedge clk);

            in_gaps_on = (p != 2) && ($urandom_range(0, 4) != 0);
            out_stalls_on = (p != 2) && ($urandom_range(0, 4) != 0);
            spin_rate = $urandom_range(0, 6000) - 3000;
            spin_jitter = $urandom_range(0, 400);

            // Weight above unity: alternating extremes push the filters into saturation
            if (p == 1)
            begin
                for (int k = 0; k < 6; k++)
                    push_frame(int'(walk_count), k[0] ? -32768 : 32767,
                               k[0] ? -32768 : 32767, k * 40);
            end
            queue_random_frames(115);
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && decoded_q.size() == 0)
            $display("motor_feedback_decoder regression: pass");
        else
            $display("motor_feedback_decoder regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("motor_feedback_decoder regression: fail");
        $finish;
    end

endmodule
